// ===== design/btz_pkg.sv =====
// Package for the battery temperature zone tracker.
// Holds the zone code and limit types and the built-in zone limit tables.
// No dependencies.
package btz_pkg;

    localparam int TEMP_W      = 12;
    localparam int LIMIT_W     = 14;
    localparam int ZONE_SLOTS  = 8;
    localparam int SLOT_W      = $clog2(ZONE_SLOTS);
    localparam int ZONE_CODE_W = SLOT_W + 1;
    localparam int ZONE_OUT_W  = 3;

    typedef logic signed [LIMIT_W-1:0] limit_t;
    typedef logic [ZONE_CODE_W-1:0]    zone_code_t;
    typedef logic [SLOT_W-1:0]         slot_t;

    typedef struct packed {
        logic       found;
        zone_code_t zone;
    } zone_pick_t;

    // Lower limit of each zone, inclusive. Unused slots hold an unreachable value.
    function automatic limit_t zone_min(input slot_t idx);
        limit_t val;
        case (idx)
            3'd0:    val = -14'sd2000;
            3'd1:    val = -14'sd80;
            3'd2:    val = 14'sd20;
            3'd3:    val = 14'sd400;
            3'd4:    val = 14'sd550;
            default: val = 14'sd4096;
        endcase
        return val;
    endfunction

    // Upper limit of each zone, exclusive.
    function automatic limit_t zone_max(input slot_t idx);
        limit_t val;
        case (idx)
            3'd0:    val = -14'sd50;
            3'd1:    val = 14'sd50;
            3'd2:    val = 14'sd430;
            3'd3:    val = 14'sd580;
            3'd4:    val = 14'sd2000;
            default: val = 14'sd4096;
        endcase
        return val;
    endfunction

    // Entry limit used when the zone is not yet known.
    function automatic limit_t zone_init(input slot_t idx);
        limit_t val;
        case (idx)
            3'd0:    val = -14'sd2000;
            3'd1:    val = -14'sd80;
            3'd2:    val = 14'sd20;
            3'd3:    val = 14'sd430;
            3'd4:    val = 14'sd580;
            default: val = 14'sd4096;
        endcase
        return val;
    endfunction

endpackage

// ===== design/btz_zone_select.sv =====
// Zone search logic: compares one sample against every zone's limits and
// picks the next zone from the current one. Depends on btz_pkg.
module btz_zone_select import btz_pkg::*; #(
    parameter int ZONE_COUNT = 5
) (
    input  logic signed [TEMP_W-1:0] temperature,
    input  zone_code_t               prev_zone,
    output zone_pick_t               pick
);

    localparam zone_code_t UNKNOWN = ZONE_CODE_W'(ZONE_COUNT);

    limit_t     temp_ext;
    logic       is_unknown;
    logic       below_min;
    logic       at_max;
    zone_pick_t pick_init;
    zone_pick_t pick_down;
    zone_pick_t pick_up;
    slot_t      prev_slot;

    assign temp_ext   = LIMIT_W'(temperature);
    assign is_unknown = (prev_zone >= UNKNOWN);
    assign prev_slot  = prev_zone[SLOT_W-1:0];
    assign below_min  = temp_ext < zone_min(prev_slot);
    assign at_max     = temp_ext >= zone_max(prev_slot);

    always_comb begin
        pick_init = '0;
        pick_down = '0;
        // Ascending scan keeps the highest matching zone.
        for (int z = 0; z < ZONE_SLOTS; z++) begin
            if (z < ZONE_COUNT) begin
                if (temp_ext > zone_init(SLOT_W'(z))) begin
                    pick_init.found = 1'b1;
                    pick_init.zone  = ZONE_CODE_W'(z);
                end
                if ((ZONE_CODE_W'(z) < prev_zone) &&
                    (temp_ext >= zone_min(SLOT_W'(z))) &&
                    (temp_ext < zone_max(SLOT_W'(z)))) begin
                    pick_down.found = 1'b1;
                    pick_down.zone  = ZONE_CODE_W'(z);
                end
            end
        end
    end

    always_comb begin
        pick_up = '0;
        // Descending scan keeps the lowest matching zone above the current one.
        for (int z = ZONE_SLOTS - 1; z >= 0; z--) begin
            if ((z < ZONE_COUNT) && (ZONE_CODE_W'(z) > prev_zone) &&
                (temp_ext >= zone_min(SLOT_W'(z))) &&
                (temp_ext < zone_max(SLOT_W'(z)))) begin
                pick_up.found = 1'b1;
                pick_up.zone  = ZONE_CODE_W'(z);
            end
        end
    end

    always_comb begin
        if (is_unknown) begin
            pick = pick_init;
        end else if (below_min) begin
            pick = pick_down;
        end else if (at_max) begin
            pick = pick_up;
        end else begin
            pick = '0;
        end
    end

endmodule

// ===== design/battery_temp_zone_hysteresis_top.sv =====
// Top level of the battery temperature zone tracker with hysteresis.
// Depends on btz_pkg and btz_zone_select.
//
//  channel | ports                                         | beat
//  --------+-----------------------------------------------+---------------------------
//  input   | s_valid s_ready s_temperature                 | one temperature sample
//  result  | m_valid m_ready m_changed m_zone m_previous_zone | one zone update per sample
//
// One sample per cycle is taken while s_ready is high. An accepted sample sits in the
// input register while the zone search runs; once the result register is free or its beat
// is taken, the search result is loaded into it and the zone state is updated.
// Reset (aresetn low at a clock edge) empties both registers and sets the zone to unknown.
// A stalled result holds the result register; the input register still accepts one
// more sample, then s_ready drops until the result is taken.
module battery_temp_zone_hysteresis_top import btz_pkg::*; #(
    parameter int ZONE_COUNT = 5
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [TEMP_W-1:0] s_temperature,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_changed,
    output logic [ZONE_OUT_W-1:0]    m_zone,
    output logic [ZONE_OUT_W-1:0]    m_previous_zone
);

    localparam zone_code_t UNKNOWN = ZONE_CODE_W'(ZONE_COUNT);

    logic                     in_valid_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    zone_code_t               zone_reg;
    zone_code_t               zone_next;
    logic                     out_valid_reg;
    logic                     changed_reg;
    logic [ZONE_OUT_W-1:0]    out_zone_reg;
    logic [ZONE_OUT_W-1:0]    prev_zone_reg;
    zone_pick_t               pick;
    logic                     out_load;
    logic                     in_load;

    btz_zone_select #(
        .ZONE_COUNT (ZONE_COUNT)
    ) u_select (
        .temperature (temp_reg),
        .prev_zone   (zone_reg),
        .pick        (pick)
    );

    assign out_load  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || out_load;
    assign in_load   = s_valid && s_ready;
    assign zone_next = pick.found ? pick.zone : zone_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            temp_reg <= s_temperature;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zone_reg <= UNKNOWN;
        end else if (out_load) begin
            zone_reg <= zone_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            changed_reg   <= pick.found;
            out_zone_reg  <= zone_next[ZONE_OUT_W-1:0];
            prev_zone_reg <= zone_reg[ZONE_OUT_W-1:0];
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_changed       = changed_reg;
    assign m_zone          = out_zone_reg;
    assign m_previous_zone = prev_zone_reg;

endmodule

// ===== design/btz_checker.sv =====
// Port-level checker for the battery temperature zone tracker, with its bind.
// Depends on btz_pkg; attaches to battery_temp_zone_hysteresis_top.
module btz_checker import btz_pkg::*; #(
    parameter int ZONE_COUNT = 5
) (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic signed [TEMP_W-1:0] s_temperature,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic                     m_changed,
    input logic [ZONE_OUT_W-1:0]    m_zone,
    input logic [ZONE_OUT_W-1:0]    m_previous_zone
);

    localparam logic [ZONE_OUT_W-1:0] UNKNOWN_OUT = ZONE_OUT_W'(ZONE_COUNT);

    logic                  seen_reg;
    logic [ZONE_OUT_W-1:0] last_zone_reg;

    // Tracks the zone of the last delivered result so the next one can be chained.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 1'b0;
        end else if (m_valid && m_ready) begin
            seen_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_valid && m_ready) begin
            last_zone_reg <= m_zone;
        end
    end

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_temperature))
        else $error("input beat changed while stalled");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable({m_changed, m_zone, m_previous_zone}))
        else $error("result beat changed while stalled");

    a_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_previous_zone == (seen_reg ? last_zone_reg : UNKNOWN_OUT))
        else $error("previous zone does not match the last delivered zone");

    // With eight zones the unknown code wraps onto zone 0, so the flag can't be
    // derived from the two codes in that configuration.
    a_changed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (ZONE_COUNT < ZONE_SLOTS) |-> m_changed == (m_zone != m_previous_zone))
        else $error("changed flag disagrees with zone codes");

    a_zone_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_zone < UNKNOWN_OUT) || (m_zone == UNKNOWN_OUT) ||
                    (ZONE_COUNT == ZONE_SLOTS))
        else $error("zone code out of range");

endmodule

bind battery_temp_zone_hysteresis_top btz_checker #(
    .ZONE_COUNT (ZONE_COUNT)
) u_btz_checker (.*);
